/* sv/lfa_pkg.sv */
// Shared types and constants for the fully associative LRU tag store.
package lfa_pkg;

  // Number of slots, key width and derived widths.
  localparam int MAX_SLOTS = 16;
  localparam int KEY_BITS  = 64;
  localparam int IN_KEY_W  = 64;
  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int STAMP_W   = 32;
  localparam int CFG_W     = 5;
  localparam int OUT_SLOT_W = 4;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } state_t;

  // Running search result handed from one cell to the next.
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [IDX_W-1:0]   hit_slot;
    logic               best_vld;
    logic [STAMP_W-1:0] best_age;
    logic [IDX_W-1:0]   best_slot;
  } scan_t;

  // Update broadcast to all cells at the end of a request.
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    slot;
    logic                key_we;
    logic [KEY_BITS-1:0] key;
    logic [STAMP_W-1:0]  stamp;
  } wr_t;

endpackage

/* sv/lfa_cell.sv */
// One tag slot: stored key and stamp, plus one stage of the hit and oldest-slot scan.
module lfa_cell
  import lfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [IDX_W-1:0]    cell_idx,
  input  logic [CNT_W-1:0]    fill_cnt,
  input  logic [CNT_W-1:0]    cap,
  input  logic [KEY_BITS-1:0] key,
  input  logic [STAMP_W-1:0]  stamp_now,
  input  scan_t               scan_in,
  output scan_t               scan_out,
  input  wr_t                 wr
);

  logic [KEY_BITS-1:0] key_r;
  logic [STAMP_W-1:0]  stamp_r;
  scan_t               scan_r;
  scan_t               scan_nxt;
  logic                filled;
  logic                elig;
  logic [STAMP_W-1:0]  age;

  // Slot is searched for hits when filled, and for a victim when within capacity.
  assign filled = {1'b0, cell_idx} < fill_cnt;
  assign elig   = {1'b0, cell_idx} < cap;
  assign age    = stamp_now - stamp_r;

  // Fold this slot into the running result; the lowest index wins ties.
  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.hit && filled && (key_r == key)) begin
      scan_nxt.hit      = 1'b1;
      scan_nxt.hit_slot = cell_idx;
    end
    if (elig && (!scan_in.best_vld || (age > scan_in.best_age))) begin
      scan_nxt.best_vld  = 1'b1;
      scan_nxt.best_age  = age;
      scan_nxt.best_slot = cell_idx;
    end
  end

  // Scan stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.vld <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;

  // Slot contents are updated when the broadcast names this slot.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.slot == cell_idx)) begin
      stamp_r <= wr.stamp;
      if (wr.key_we) begin
        key_r <= wr.key;
      end
    end
  end

endmodule

/* sv/lru_fully_associative_lookup.sv */
// Top level of the fully associative LRU tag store: control, counters and the cell row.
//
//   channel  | ports                                       | flow control
//   ---------+---------------------------------------------+---------------------------
//   request  | start, in_page_key, busy                    | taken when start && !busy
//   result   | out_valid, out_was_hit, out_slot_used       | one-cycle strobe, no stall
//   config   | cfg_valid, cfg_slots_in_use, cfg_ready      | taken when valid && ready
//
// The result strobe follows acceptance: the accepting edge latches the key, the scan token
// then moves one cell per edge along the row of MAX_SLOTS cells, and the next edge applies
// the update and loads the result. busy is high from acceptance until the result strobe;
// a new request can be taken at the edge that ends the strobe cycle, so a request cannot
// start before the last one is done. Reset clears the fill count and access counter and
// sets capacity to MAX_SLOTS; slot contents are not cleared. The result cannot be held off.
module lru_fully_associative_lookup
  import lfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [IN_KEY_W-1:0]   in_page_key,
  output logic                  busy,
  output logic                  out_valid,
  output logic                  out_was_hit,
  output logic [OUT_SLOT_W-1:0] out_slot_used,
  input  logic                  cfg_valid,
  input  logic [CFG_W-1:0]      cfg_slots_in_use,
  output logic                  cfg_ready
);

  state_t              state_r;
  state_t              state_nxt;
  logic                inject_r;
  logic [KEY_BITS-1:0] key_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [CNT_W-1:0]    filled_r;
  logic [CNT_W-1:0]    filled_nxt;
  logic [CFG_W-1:0]    slots_in_use_r;
  logic [CNT_W-1:0]    cap;
  logic                out_valid_r;
  logic                out_hit_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic                accept;
  scan_t               chain_head;
  scan_t               chain [MAX_SLOTS+1];
  scan_t               last;
  wr_t                 wr;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // Capacity clamped to 1 .. MAX_SLOTS.
  always_comb begin
    if (slots_in_use_r == '0) begin
      cap = CNT_W'(1);
    end else if (32'(slots_in_use_r) > MAX_SLOTS) begin
      cap = CNT_W'(MAX_SLOTS);
    end else begin
      cap = CNT_W'(slots_in_use_r);
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= CFG_W'(MAX_SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      slots_in_use_r <= cfg_slots_in_use;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (last.vld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    case (state_r)
      ST_IDLE:  busy = 1'b0;
      ST_SWEEP: busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  // Control registers and the access counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inject_r    <= 1'b0;
      stamp_r     <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inject_r    <= accept;
      filled_r    <= filled_nxt;
      out_valid_r <= wr.en;
      if (accept) begin
        stamp_r <= stamp_r + STAMP_W'(1);
      end
    end
  end

  // Request key latch.
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_page_key[KEY_BITS-1:0];
    end
  end

  // Scan token enters the first cell with an empty result.
  always_comb begin
    chain_head     = '0;
    chain_head.vld = inject_r;
  end

  assign chain[0] = chain_head;

  // Row of slot cells.
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    lfa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .fill_cnt  (filled_r),
      .cap       (cap),
      .key       (key_r),
      .stamp_now (stamp_r),
      .scan_in   (chain[g]),
      .scan_out  (chain[g+1]),
      .wr        (wr)
    );
  end

  assign last = chain[MAX_SLOTS];

  // Pick the slot: hit, next empty slot, or the oldest slot within capacity.
  always_comb begin
    filled_nxt = filled_r;
    wr.en      = last.vld;
    wr.key     = key_r;
    wr.stamp   = stamp_r;
    if (last.hit) begin
      wr.slot   = last.hit_slot;
      wr.key_we = 1'b0;
    end else if (filled_r < cap) begin
      wr.slot   = filled_r[IDX_W-1:0];
      wr.key_we = 1'b1;
      if (last.vld) filled_nxt = filled_r + CNT_W'(1);
    end else begin
      wr.slot   = last.best_slot;
      wr.key_we = 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      out_hit_r  <= last.hit;
      out_slot_r <= wr.slot;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_was_hit   = out_hit_r;
  assign out_slot_used = OUT_SLOT_W'(out_slot_r);

endmodule
